// ----- design/s3hs_pkg.sv -----
// Package for the separable 3-D stencil: sizes, CSR indices, coefficient table, FSM states, command and status types.
// No dependencies.
`timescale 1ns / 1ps
package s3hs_pkg;
   localparam int MAX_ROW_DEF = 64;
   localparam int MAX_ROWS_DEF = 64;
   localparam int MAX_TAPS_DEF = 5;
   localparam int SAMPLE_BITS_DEF = 32;
   localparam int CSR_IDX_BITS = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_ORDER = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_KINDS = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_SCALE = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_X = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_Y = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE_Z = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_ZPASS, ST_YPASS, ST_XPASS, ST_SCALE, ST_OUT
   } state_type;

   typedef struct packed {
      logic start;
      logic rd_step;
      logic z_step;
      logic y_step;
      logic x_step;
      logic scale_go;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic rd_done;
      logic z_done;
      logic y_done;
      logic x_done;
   } sts_type;

   function automatic logic signed [17:0] coef(input logic kind, input logic [1:0] ord,
                                               input logic [2:0] tap);
      logic signed [17:0] c;
      begin
         c = 18'sd0;
         case (ord)
            2'd0: c = (tap == 3'd2) ? 18'sd65536 : 18'sd0;
            2'd1: begin
               if (tap == 3'd2) c = kind ? 18'sd70997 : 18'sd60075;
               else if (tap == 3'd1 || tap == 3'd3) c = kind ? -18'sd2731 : 18'sd2731;
            end
            default: begin
               case (tap)
                  3'd0, 3'd4: c = kind ? 18'sd307 : -18'sd193;
                  3'd1, 3'd3: c = kind ? -18'sd3959 : 18'sd3504;
                  3'd2: c = kind ? 18'sd72841 : 18'sd58914;
                  default: c = 18'sd0;
               endcase
            end
         endcase
         return c;
      end
   endfunction
endpackage

// ----- design/separable_3d_hodge_stencil.sv -----
// Channel  | handshake           | payload
// req      | req_valid/req_stall | req_sample_value
// rsp      | rsp_valid/rsp_stall | rsp_result_value, rsp_last_of_grid
// csr      | csr_valid/csr_ready | csr_index, csr_data
// A word that yields no result returns to idle from the read state. A word with a result reads its
// w*w*w window (w of 1, 3 or 5 taps) through the single memory read port while the z pass
// accumulates each sample in the cycle after its read, then runs the y and x passes on
// one shared multiplier, one tap per cycle, then scales and shows the result, waiting out
// any output stall. The input stalls meanwhile.
// Reset is synchronous; memory contents are not cleared.
// Top level; depends on s3hs_pkg, s3hs_ctrl and s3hs_dp.
`timescale 1ns / 1ps
module separable_3d_hodge_stencil #(
   parameter int MAX_ROW = s3hs_pkg::MAX_ROW_DEF,
   parameter int MAX_ROWS = s3hs_pkg::MAX_ROWS_DEF,
   parameter int MAX_TAPS = s3hs_pkg::MAX_TAPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_sample_value,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic signed [31:0] rsp_result_value,
   output logic rsp_last_of_grid,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [s3hs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0] csr_data
);
   import s3hs_pkg::*;
   cmd_type cmd;
   sts_type sts;
   s3hs_ctrl u_ctrl (.clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall,
                     .sts, .cmd);
   s3hs_dp #(.MAX_ROW(MAX_ROW), .MAX_ROWS(MAX_ROWS), .MAX_TAPS(MAX_TAPS)) u_dp (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data, .req_sample_value,
      .cmd, .sts, .rsp_result_value, .rsp_last_of_grid);

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input taken while result pending");
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.start, cmd.rd_step, cmd.z_step, cmd.y_step, cmd.x_step, cmd.scale_go}))
      else $error("overlapping commands");
   a_scale_then_out: assert property (@(posedge clock) disable iff (reset)
      cmd.scale_go |=> rsp_valid) else $error("result not shown after scaling");
endmodule

// ----- design/s3hs_ctrl.sv -----
// Controller state machine sequencing reads, the z, y, x passes, scaling and output.
// Depends on s3hs_pkg.
`timescale 1ns / 1ps
module s3hs_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   output logic rsp_valid,
   input  logic rsp_stall,
   input  s3hs_pkg::sts_type sts,
   output s3hs_pkg::cmd_type cmd
);
   import s3hs_pkg::*;
   state_type state_ff, state_in;
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!sts.emit) state_in = ST_IDLE;
            else begin
               cmd.rd_step = 1'b1;
               if (sts.rd_done) state_in = ST_ZPASS;
            end
         end
         ST_ZPASS: begin
            cmd.z_step = 1'b1;
            if (sts.z_done) state_in = ST_YPASS;
         end
         ST_YPASS: begin
            cmd.y_step = 1'b1;
            if (sts.y_done) state_in = ST_XPASS;
         end
         ST_XPASS: begin
            cmd.x_step = 1'b1;
            if (sts.x_done) state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_go = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ----- design/s3hs_dp.sv -----
// Datapath: plane memory, streamed z pass, one shared multiply-accumulate, scaling.
// Depends on s3hs_pkg.
`timescale 1ns / 1ps
module s3hs_dp #(
   parameter int MAX_ROW = s3hs_pkg::MAX_ROW_DEF,
   parameter int MAX_ROWS = s3hs_pkg::MAX_ROWS_DEF,
   parameter int MAX_TAPS = s3hs_pkg::MAX_TAPS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [s3hs_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [31:0] csr_data,
   input  logic signed [31:0] req_sample_value,
   input  s3hs_pkg::cmd_type cmd,
   output s3hs_pkg::sts_type sts,
   output logic signed [31:0] rsp_result_value,
   output logic rsp_last_of_grid
);
   import s3hs_pkg::*;
   localparam int XB = $clog2(MAX_ROW);
   localparam int YB = $clog2(MAX_ROWS);
   localparam int ZS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int DEPTH = MAX_TAPS * MAX_ROW * MAX_ROWS;
   localparam int AB = $clog2(DEPTH);
   localparam int MAXORD = (MAX_TAPS - 1) / 2;
   localparam int ACCB = 64;
   localparam logic [3:0] TAPS4 = 4'(MAX_TAPS);

   logic [1:0] order_ff;
   logic [2:0] kinds_ff;
   logic [31:0] scale_ff;
   logic [6:0] size_x_ff, size_y_ff;
   logic [11:0] size_z_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 2'd0; kinds_ff <= 3'd0; scale_ff <= 32'd65536;
         size_x_ff <= 7'd64; size_y_ff <= 7'd64; size_z_ff <= 12'd64;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_ORDER: order_ff <= csr_data[1:0];
            REG_KINDS: kinds_ff <= csr_data[2:0];
            REG_SCALE: scale_ff <= csr_data;
            REG_SIZE_X: size_x_ff <= csr_data[6:0];
            REG_SIZE_Y: size_y_ff <= csr_data[6:0];
            REG_SIZE_Z: size_z_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   logic [11:0] sx, sy, sz;
   logic [1:0] ord;
   always_comb begin
      sx = (size_x_ff == 7'd0) ? 12'd1 : ({5'd0, size_x_ff} > 12'(MAX_ROW) ? 12'(MAX_ROW)
           : {5'd0, size_x_ff});
      sy = (size_y_ff == 7'd0) ? 12'd1 : ({5'd0, size_y_ff} > 12'(MAX_ROWS) ? 12'(MAX_ROWS)
           : {5'd0, size_y_ff});
      sz = (size_z_ff == 12'd0) ? 12'd1 : size_z_ff;
      ord = (order_ff == 2'd3) ? 2'd2 : order_ff;
      if (32'(ord) > 32'(MAXORD)) ord = 2'(MAXORD);
   end

   logic [11:0] px_ff, py_ff, pz_ff;
   logic [ZS-1:0] zm_ff, zb_ff;
   logic [11:0] cx_ff, cy_ff;
   logic [1:0] h_ff;
   logic [2:0] kk_ff;
   logic emit_ff, last_ff;
   logic [11:0] h2;
   assign h2 = {9'd0, ord, 1'b0};

   logic [3:0] zm4, hh4, zb4;
   always_comb begin
      zm4 = 4'(zm_ff);
      hh4 = {1'b0, ord, 1'b0};
      zb4 = (zm4 >= hh4) ? zm4 - hh4 : zm4 + TAPS4 - hh4;
   end

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;
   logic [AB-1:0] wr_addr, rd_addr;
   logic [2:0] ia_ff, ib_ff, ic_ff;
   logic rd_vld_ff;
   logic [2:0] w;
   assign w = {h_ff, 1'b1};

   function automatic logic [ZS-1:0] zmod_inc(input logic [ZS-1:0] v);
      return (32'(v) == MAX_TAPS - 1) ? '0 : v + 1'b1;
   endfunction

   assign wr_addr = AB'(zm_ff) * AB'(MAX_ROW * MAX_ROWS)
                    + AB'(py_ff[YB-1:0]) * AB'(MAX_ROW) + AB'(px_ff[XB-1:0]);
   logic [11:0] rx, ry;
   logic [3:0] rz4;
   logic [ZS-1:0] rzm;
   always_comb begin
      rx = cx_ff - {10'd0, h_ff} + {9'd0, ia_ff};
      ry = cy_ff - {10'd0, h_ff} + {9'd0, ib_ff};
      rz4 = 4'(zb_ff) + {1'b0, ic_ff};
      rzm = ZS'((rz4 >= TAPS4) ? rz4 - TAPS4 : rz4);
   end
   assign rd_addr = AB'(rzm) * AB'(MAX_ROW * MAX_ROWS)
                    + AB'(ry[YB-1:0]) * AB'(MAX_ROW) + AB'(rx[XB-1:0]);

   always_ff @(posedge clock) begin
      if (cmd.start) mem[wr_addr] <= req_sample_value;
      rd_data_ff <= mem[rd_addr];
   end

   logic signed [31:0] t2_ff [5][5];
   logic signed [31:0] t1_ff [5];
   logic signed [31:0] xr_ff;
   logic [2:0] pa_ff, pb_ff, pc_ff;
   logic signed [ACCB-1:0] acc_ff;

   function automatic logic signed [31:0] rnd_sat(input logic signed [ACCB-1:0] a);
      logic [ACCB-1:0] m, r;
      logic signed [ACCB-1:0] s, hi, lo;
      begin
         m = a[ACCB-1] ? -a : a;
         r = (m + ACCB'(32768)) >> 16;
         s = a[ACCB-1] ? -$signed(r) : $signed(r);
         hi = (ACCB'(1) <<< (SAMPLE_BITS_DEF - 1)) - ACCB'(1);
         lo = -hi - ACCB'(1);
         if (s > hi) s = hi;
         else if (s < lo) s = lo;
         return 32'(s);
      end
   endfunction

   logic signed [31:0] mac_a;
   logic signed [17:0] mac_c;
   logic signed [49:0] mac_m;
   logic signed [ACCB-1:0] mac_p;
   logic [2:0] tap;
   logic kind;
   always_comb begin
      mac_a = '0; kind = 1'b0; tap = 3'd0;
      if (rd_vld_ff) begin
         mac_a = rd_data_ff; kind = kk_ff[2]; tap = pc_ff;
      end else if (cmd.y_step) begin
         mac_a = t2_ff[pb_ff][pa_ff]; kind = kk_ff[1]; tap = pb_ff;
      end else begin
         mac_a = t1_ff[pa_ff]; kind = kk_ff[0]; tap = pa_ff;
      end
      mac_c = coef(kind, h_ff, tap + 3'd2 - {1'b0, h_ff});
      mac_m = mac_a * mac_c;
      mac_p = ACCB'(mac_m);
   end

   logic signed [ACCB-1:0] acc_n;
   assign acc_n = acc_ff + mac_p;
   logic rd_last;
   assign rd_last = (ia_ff == w - 3'd1) && (ib_ff == w - 3'd1) && (ic_ff == w - 3'd1);

   logic [31:0] mag;
   logic [63:0] prod;
   logic [47:0] r;
   logic signed [31:0] scaled;
   always_comb begin
      mag = xr_ff[31] ? 32'(-xr_ff) : 32'(xr_ff);
      prod = mag * scale_ff;
      r = 48'((prod + 64'd32768) >> 16);
      if (xr_ff[31]) scaled = (r > 48'h80000000) ? 32'h80000000 : 32'(-r);
      else scaled = (r > 48'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(r);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0; py_ff <= '0; pz_ff <= '0; zm_ff <= '0;
         emit_ff <= 1'b0; rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_step;
         if (cmd.start) begin
            emit_ff <= px_ff < sx && py_ff < sy && pz_ff < sz &&
                       px_ff >= h2 && py_ff >= h2 && pz_ff >= h2;
            last_ff <= px_ff == sx - 12'd1 && py_ff == sy - 12'd1 && pz_ff == sz - 12'd1;
            cx_ff <= px_ff - {10'd0, ord}; cy_ff <= py_ff - {10'd0, ord};
            zb_ff <= ZS'(zb4);
            h_ff <= ord; kk_ff <= kinds_ff;
            ia_ff <= '0; ib_ff <= '0; ic_ff <= '0;
            pa_ff <= '0; pb_ff <= '0; pc_ff <= '0;
            acc_ff <= '0;
            if (px_ff + 12'd1 >= sx) begin
               px_ff <= '0;
               if (py_ff + 12'd1 >= sy) begin
                  py_ff <= '0;
                  if (pz_ff + 12'd1 >= sz) begin
                     pz_ff <= '0; zm_ff <= '0;
                  end else begin
                     pz_ff <= pz_ff + 12'd1; zm_ff <= zmod_inc(zm_ff);
                  end
               end else py_ff <= py_ff + 12'd1;
            end else px_ff <= px_ff + 12'd1;
         end
      end
      if (cmd.rd_step && !rd_last) begin
         if (ic_ff != w - 3'd1) ic_ff <= ic_ff + 3'd1;
         else begin
            ic_ff <= '0;
            if (ia_ff != w - 3'd1) ia_ff <= ia_ff + 3'd1;
            else begin ia_ff <= '0; ib_ff <= ib_ff + 3'd1; end
         end
      end
      if (rd_vld_ff) begin
         if (pc_ff != w - 3'd1) begin
            acc_ff <= acc_n; pc_ff <= pc_ff + 3'd1;
         end else begin
            t2_ff[pb_ff][pa_ff] <= rnd_sat(acc_n); acc_ff <= '0; pc_ff <= '0;
            if (pa_ff != w - 3'd1) pa_ff <= pa_ff + 3'd1;
            else begin
               pa_ff <= '0;
               pb_ff <= (pb_ff != w - 3'd1) ? pb_ff + 3'd1 : 3'd0;
            end
         end
      end
      if (cmd.y_step) begin
         if (pb_ff != w - 3'd1) begin
            acc_ff <= acc_n; pb_ff <= pb_ff + 3'd1;
         end else begin
            t1_ff[pa_ff] <= rnd_sat(acc_n); acc_ff <= '0; pb_ff <= '0;
            pa_ff <= (pa_ff != w - 3'd1) ? pa_ff + 3'd1 : 3'd0;
         end
      end
      if (cmd.x_step) begin
         if (pa_ff != w - 3'd1) begin
            acc_ff <= acc_n; pa_ff <= pa_ff + 3'd1;
         end else begin
            xr_ff <= rnd_sat(acc_n); acc_ff <= '0; pa_ff <= '0;
         end
      end
      if (cmd.scale_go) begin
         rsp_result_value <= scaled;
         rsp_last_of_grid <= last_ff;
      end
   end

   always_comb begin
      sts.emit = emit_ff;
      sts.rd_done = rd_last;
      sts.z_done = rd_vld_ff && (pc_ff == w - 3'd1) && (pa_ff == w - 3'd1) &&
                   (pb_ff == w - 3'd1);
      sts.y_done = (pb_ff == w - 3'd1) && (pa_ff == w - 3'd1);
      sts.x_done = (pa_ff == w - 3'd1);
   end
endmodule
